FILE: hdl/bfs_pkg.sv
// ---------------------------------------------------------------------------
// Beacon frame serializer package
// Shared types, constants and byte tables for the beacon frame serializer.
// ---------------------------------------------------------------------------
package bfs_pkg;

    localparam int unsigned MAX_SSID_BYTES_DEF = 32;
    localparam int unsigned HEADER_BYTES       = 38;
    localparam int unsigned TRAILER_BYTES      = 13;
    localparam int unsigned RATES_BYTES        = 10;

    localparam logic [5:0] HDR_LAST = 6'(HEADER_BYTES - 1);
    localparam logic [5:0] TRL_LAST = 6'(TRAILER_BYTES - 1);

    // Request codes of an input word
    localparam logic REQ_START = 1'b0;
    localparam logic REQ_SSID  = 1'b1;

    // Supported rates element, id and length included
    localparam logic [7:0] RATES_ELEM [RATES_BYTES] = '{
        8'h01, 8'h08, 8'h82, 8'h84, 8'h8b, 8'h96, 8'h24, 8'h30, 8'h48, 8'h6c
    };

    // DS parameter set element id and length
    localparam logic [7:0] DS_ELEM_ID  = 8'h03;
    localparam logic [7:0] DS_ELEM_LEN = 8'h01;

    typedef struct packed {
        logic [7:0]  frame_byte;
        logic        frame_last;
        logic [31:0] frame_count;
    } out_word_t;

    // One octet of the 48-bit address, first octet in the top bits
    function automatic logic [7:0] addr_octet(input logic [2:0] idx, input logic [47:0] addr);
        logic [7:0] b;
        unique case (idx)
            3'd0:    b = addr[47:40];
            3'd1:    b = addr[39:32];
            3'd2:    b = addr[31:24];
            3'd3:    b = addr[23:16];
            3'd4:    b = addr[15:8];
            3'd5:    b = addr[7:0];
            default: b = 8'h00;
        endcase
        return b;
    endfunction

    // Byte at a given position of the 38-byte management header
    function automatic logic [7:0] hdr_byte(input logic [5:0] pos, input logic [47:0] addr,
                                            input logic [5:0] len);
        logic [7:0] b;
        logic [5:0] rel;
        rel = 6'd0;
        priority if (pos == 6'd0) begin
            b = 8'h80;
        end else if (pos < 6'd4) begin
            b = 8'h00;
        end else if (pos < 6'd10) begin
            b = 8'hff;
        end else if (pos < 6'd16) begin
            rel = pos - 6'd10;
            b = addr_octet(rel[2:0], addr);
        end else if (pos < 6'd22) begin
            rel = pos - 6'd16;
            b = addr_octet(rel[2:0], addr);
        end else begin
            unique case (pos)
                6'd24:   b = 8'h83;
                6'd25:   b = 8'h51;
                6'd26:   b = 8'hf7;
                6'd27:   b = 8'h8f;
                6'd28:   b = 8'h0f;
                6'd32:   b = 8'he8;
                6'd33:   b = 8'h03;
                6'd34:   b = 8'h31;
                6'd35:   b = 8'h04;
                6'd37:   b = {2'b00, len};
                default: b = 8'h00;
            endcase
        end
        return b;
    endfunction

    // Byte at a given position of the rates and channel trailer
    function automatic logic [7:0] trl_byte(input logic [5:0] pos, input logic [7:0] chan);
        logic [7:0] b;
        if (pos < 6'(RATES_BYTES)) begin
            b = RATES_ELEM[pos[3:0]];
        end else if (pos == 6'(RATES_BYTES)) begin
            b = DS_ELEM_ID;
        end else if (pos == 6'(RATES_BYTES + 1)) begin
            b = DS_ELEM_LEN;
        end else begin
            b = chan;
        end
        return b;
    endfunction

endpackage

FILE: hdl/beacon_frame_serializer.sv
// ---------------------------------------------------------------------------
// Beacon frame serializer
// Builds an 802.11 beacon management frame as a stream of bytes.
// ---------------------------------------------------------------------------
// A start word occupies the block for its 38 header bytes, and also for the
// trailer when the SSID length is zero, as the trailer then follows at once. An
// SSID word occupies it for its echo byte, and the last SSID byte also for the
// rates and channel elements that follow it; an SSID word outside a frame
// yields nothing. The byte sequencer hands one frame byte per cycle, while the
// queue has space, to a two-entry output queue; the next word is taken in
// the cycle that the previous word's last byte leaves the sequencer, so SSID
// words stream at one per cycle while the output queue has space.
// ---------------------------------------------------------------------------
module beacon_frame_serializer
    import bfs_pkg::*;
#(
    parameter int unsigned MAX_SSID_BYTES = MAX_SSID_BYTES_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_req_type,
    input  logic [47:0] s_source_mac,
    input  logic [7:0]  s_channel_number,
    input  logic [5:0]  s_ssid_length,
    input  logic [7:0]  s_ssid_byte,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [7:0]  m_frame_byte,
    output logic        m_frame_last,
    output logic [31:0] m_frame_count
);

    logic      push;
    logic      space;
    out_word_t push_word;
    out_word_t m_word;

    bfs_frame_ctrl #(
        .MAX_SSID_BYTES (MAX_SSID_BYTES)
    ) u_ctrl (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_req_type       (s_req_type),
        .s_source_mac     (s_source_mac),
        .s_channel_number (s_channel_number),
        .s_ssid_length    (s_ssid_length),
        .s_ssid_byte      (s_ssid_byte),
        .space            (space),
        .push             (push),
        .push_word        (push_word)
    );

    bfs_out_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_word (push_word),
        .space     (space),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_word    (m_word)
    );

    assign m_frame_byte  = m_word.frame_byte;
    assign m_frame_last  = m_word.frame_last;
    assign m_frame_count = m_word.frame_count;

endmodule

FILE: hdl/bfs_out_queue.sv
// ---------------------------------------------------------------------------
// Beacon frame serializer output queue
// Two-entry queue between the byte sequencer and the result channel, so that
// the sequencer never waits on the downstream ready combinationally.
// ---------------------------------------------------------------------------
module bfs_out_queue
    import bfs_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        push,
    input  out_word_t   push_word,
    output logic        space,
    output logic        m_valid,
    input  logic        m_ready,
    output out_word_t   m_word
);

    out_word_t   entry_reg [2];
    logic        wr_ptr_reg;
    logic        wr_ptr_next;
    logic        rd_ptr_reg;
    logic        rd_ptr_next;
    logic [1:0]  count_reg;
    logic [1:0]  count_next;
    logic        pop;

    assign space   = (count_reg != 2'd2);
    assign m_valid = (count_reg != 2'd0);
    assign m_word  = entry_reg[rd_ptr_reg];
    assign pop     = m_valid && m_ready;

    always_comb begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_word;
        end
    end

endmodule

FILE: hdl/bfs_frame_ctrl.sv
// ---------------------------------------------------------------------------
// Beacon frame serializer control
// Takes input words, keeps the frame state and steps through the header,
// SSID echo and trailer bytes, one byte per cycle while the output queue has space.
// ---------------------------------------------------------------------------
module bfs_frame_ctrl
    import bfs_pkg::*;
#(
    parameter int unsigned MAX_SSID_BYTES = MAX_SSID_BYTES_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_req_type,
    input  logic [47:0] s_source_mac,
    input  logic [7:0]  s_channel_number,
    input  logic [5:0]  s_ssid_length,
    input  logic [7:0]  s_ssid_byte,
    input  logic        space,
    output logic        push,
    output out_word_t   push_word
);

    typedef enum logic [3:0] {
        ST_IDLE    = 4'b0001,
        ST_HEADER  = 4'b0010,
        ST_ECHO    = 4'b0100,
        ST_TRAILER = 4'b1000
    } seq_state_t;

    localparam logic [5:0] LEN_MAX = 6'(MAX_SSID_BYTES);

    seq_state_t  state_reg;
    seq_state_t  state_next;
    logic [5:0]  pos_reg;
    logic [5:0]  pos_next;
    logic        pend_reg;
    logic        pend_next;
    logic        open_reg;
    logic        open_next;
    logic [5:0]  remain_reg;
    logic [5:0]  remain_next;
    logic [31:0] count_reg;
    logic [31:0] count_next;

    logic [47:0] addr_reg;
    logic [7:0]  chan_reg;
    logic [5:0]  len_reg;
    logic [7:0]  echo_reg;

    logic        emit;
    logic        item_done;
    logic        accept;
    logic        last_byte;
    logic [5:0]  len_sat;
    logic [47:0] addr_fixed;
    logic [7:0]  byte_sel;

    assign len_sat    = (s_ssid_length > LEN_MAX) ? LEN_MAX : s_ssid_length;
    // Clear the group bit, set the locally administered bit of the first octet
    assign addr_fixed = {s_source_mac[47:42], 2'b10, s_source_mac[39:0]};

    assign emit      = (state_reg != ST_IDLE) && space;
    assign last_byte = (state_reg == ST_TRAILER) && (pos_reg == TRL_LAST);
    assign item_done = emit && (((state_reg == ST_HEADER) && (pos_reg == HDR_LAST) && !pend_reg)
                             || ((state_reg == ST_ECHO) && !pend_reg)
                             || last_byte);
    assign s_ready   = (state_reg == ST_IDLE) || item_done;
    assign accept    = s_valid && s_ready;

    always_comb begin
        unique case (state_reg)
            ST_HEADER:  byte_sel = hdr_byte(pos_reg, addr_reg, len_reg);
            ST_ECHO:    byte_sel = echo_reg;
            ST_TRAILER: byte_sel = trl_byte(pos_reg, chan_reg);
            default:    byte_sel = 8'h00;
        endcase
    end

    // The final byte already counts the frame that it completes.
    assign push                  = emit;
    assign push_word.frame_byte  = byte_sel;
    assign push_word.frame_last  = last_byte;
    assign push_word.frame_count = count_reg + 32'(last_byte);

    always_comb begin
        state_next  = state_reg;
        pos_next    = pos_reg;
        pend_next   = pend_reg;
        open_next   = open_reg;
        remain_next = remain_reg;
        count_next  = count_reg;

        if (emit) begin
            unique case (state_reg)
                ST_HEADER: begin
                    if (pos_reg == HDR_LAST) begin
                        state_next = pend_reg ? ST_TRAILER : ST_IDLE;
                        pos_next   = 6'd0;
                        pend_next  = 1'b0;
                    end else begin
                        pos_next = pos_reg + 6'd1;
                    end
                end
                ST_ECHO: begin
                    state_next = pend_reg ? ST_TRAILER : ST_IDLE;
                    pos_next   = 6'd0;
                    pend_next  = 1'b0;
                end
                ST_TRAILER: begin
                    if (pos_reg == TRL_LAST) begin
                        state_next = ST_IDLE;
                        pos_next   = 6'd0;
                        count_next = count_reg + 32'd1;
                    end else begin
                        pos_next = pos_reg + 6'd1;
                    end
                end
                default: begin
                end
            endcase
        end

        // Frame state moves on when a word is taken, so a later word always sees it.
        if (accept) begin
            if (s_req_type == REQ_START) begin
                state_next  = ST_HEADER;
                pos_next    = 6'd0;
                pend_next   = (len_sat == 6'd0);
                open_next   = (len_sat != 6'd0);
                remain_next = len_sat;
            end else if (open_reg && (remain_reg != 6'd0)) begin
                state_next  = ST_ECHO;
                pos_next    = 6'd0;
                pend_next   = (remain_reg == 6'd1);
                open_next   = (remain_reg != 6'd1);
                remain_next = remain_reg - 6'd1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_IDLE;
            pos_reg    <= 6'd0;
            pend_reg   <= 1'b0;
            open_reg   <= 1'b0;
            remain_reg <= 6'd0;
            count_reg  <= 32'd0;
        end else begin
            state_reg  <= state_next;
            pos_reg    <= pos_next;
            pend_reg   <= pend_next;
            open_reg   <= open_next;
            remain_reg <= remain_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            if (s_req_type == REQ_START) begin
                addr_reg <= addr_fixed;
                chan_reg <= s_channel_number;
                len_reg  <= len_sat;
            end else begin
                echo_reg <= s_ssid_byte;
            end
        end
    end

endmodule

FILE: tb/sv/beacon_frame_serializer_test.sv
// ---------------------------------------------------------------------------
// Beacon frame serializer testbench
// Drives start and SSID words into the serializer and checks every frame
// byte, the final-byte flag and the frame count against a byte-level
// predictor of the beacon frame. A short directed table covers the extremes
// and corner cases, then random frames run under three idling patterns.
// ---------------------------------------------------------------------------
module beacon_frame_serializer_test;
    import bfs_pkg::*;

    localparam int MAX_SSID       = MAX_SSID_BYTES_DEF;
    localparam int DIRECTED_ROWS  = 18;
    localparam int WORDS_PER_PASS = 160;
    localparam int HOLD_OFF       = 400;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int TAIL_CYCLES    = 64;

    localparam logic [7:0] HDR_TAIL [15] = '{
        8'h00, 8'h00, 8'h83, 8'h51, 8'hf7, 8'h8f, 8'h0f, 8'h00,
        8'h00, 8'h00, 8'he8, 8'h03, 8'h31, 8'h04, 8'h00
    };
    localparam logic [7:0] RATES [10] = '{
        8'h01, 8'h08, 8'h82, 8'h84, 8'h8b, 8'h96, 8'h24, 8'h30, 8'h48, 8'h6c
    };

    typedef enum logic [1:0] {
        CHECK_PREDICTED,
        CHECK_NO_WORD,
        CHECK_ONE_WORD
    } row_check_t;

    typedef struct packed {
        logic        req;
        logic [47:0] mac;
        logic [7:0]  chan;
        logic [5:0]  len;
        logic [7:0]  ssid;
        row_check_t  check;
        logic [7:0]  t_byte;
        logic [31:0] t_cnt;
    } stim_row_t;

    typedef struct packed {
        logic [7:0]  octet;
        logic        is_last;
        logic [31:0] frame_cnt;
    } beacon_word_t;

    logic        aclk             = 1'b0;
    logic        aresetn          = 1'b0;
    logic        s_valid          = 1'b0;
    logic        s_ready;
    logic        s_req_type       = REQ_START;
    logic [47:0] s_source_mac     = '0;
    logic [7:0]  s_channel_number = '0;
    logic [5:0]  s_ssid_length    = '0;
    logic [7:0]  s_ssid_byte      = '0;
    logic        m_valid;
    logic        m_ready          = 1'b0;
    logic [7:0]  m_frame_byte;
    logic        m_frame_last;
    logic [31:0] m_frame_count;

    // Typed expectation travelling alongside the word on offer.
    row_check_t  row_check = CHECK_PREDICTED;
    logic [7:0]  row_byte  = '0;
    logic [31:0] row_cnt   = '0;

    // Predictor state.
    logic [47:0] bcn_addr    = '0;
    logic [7:0]  bcn_chan    = '0;
    logic [5:0]  ssid_left   = '0;
    logic        frame_open  = 1'b0;
    logic [31:0] frames_done = '0;

    beacon_word_t expected_bytes [$];
    beacon_word_t discarded [$];

    int mismatches     = 0;
    int stalled_cycles = 0;
    int fed_words      = 0;
    int tx_idle_pct    = 0;
    int rx_idle_pct    = 0;
    logic hold_off_req = 1'b0;

    stim_row_t directed_rows [DIRECTED_ROWS] = '{
        '{REQ_SSID,  48'h0,            8'h00, 6'd0,  8'h5a, CHECK_NO_WORD,   8'h00, 32'd0},
        '{REQ_START, 48'h0,            8'h00, 6'd0,  8'h00, CHECK_PREDICTED, 8'h00, 32'd0},
        '{REQ_START, 48'hffffffffffff, 8'hff, 6'd1,  8'h00, CHECK_PREDICTED, 8'h00, 32'd0},
        '{REQ_SSID,  48'h0,            8'h00, 6'd0,  8'hff, CHECK_PREDICTED, 8'h00, 32'd0},
        '{REQ_SSID,  48'h0,            8'h00, 6'd0,  8'h00, CHECK_NO_WORD,   8'h00, 32'd0},
        '{REQ_START, 48'h0123456789ab, 8'h01, 6'd3,  8'h00, CHECK_PREDICTED, 8'h00, 32'd0},
        '{REQ_SSID,  48'h0,            8'h00, 6'd0,  8'h00, CHECK_ONE_WORD,  8'h00, 32'd2},
        '{REQ_SSID,  48'h0,            8'h00, 6'd0,  8'h7e, CHECK_ONE_WORD,  8'h7e, 32'd2},
        '{REQ_START, 48'hfedcba987654, 8'h80, 6'd63, 8'h00, CHECK_PREDICTED, 8'h00, 32'd0},
        '{REQ_SSID,  48'h0,            8'h00, 6'd0,  8'h41, CHECK_ONE_WORD,  8'h41, 32'd2},
        '{REQ_START, 48'h020000000000, 8'h0e, 6'd32, 8'h00, CHECK_PREDICTED, 8'h00, 32'd0},
        '{REQ_SSID,  48'h0,            8'h00, 6'd0,  8'h20, CHECK_ONE_WORD,  8'h20, 32'd2},
        '{REQ_START, 48'h55aa55aa55aa, 8'h06, 6'd33, 8'h00, CHECK_PREDICTED, 8'h00, 32'd0},
        '{REQ_START, 48'haa55aa55aa55, 8'h0b, 6'd2,  8'h00, CHECK_PREDICTED, 8'h00, 32'd0},
        '{REQ_SSID,  48'h0,            8'h00, 6'd0,  8'h61, CHECK_ONE_WORD,  8'h61, 32'd2},
        '{REQ_SSID,  48'h0,            8'h00, 6'd0,  8'h62, CHECK_PREDICTED, 8'h00, 32'd0},
        '{REQ_SSID,  48'h0,            8'h00, 6'd0,  8'h63, CHECK_NO_WORD,   8'h00, 32'd0},
        '{REQ_START, 48'h00ff00ff00ff, 8'ha5, 6'd0,  8'h00, CHECK_PREDICTED, 8'h00, 32'd0}
    };

    beacon_frame_serializer dut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_req_type       (s_req_type),
        .s_source_mac     (s_source_mac),
        .s_channel_number (s_channel_number),
        .s_ssid_length    (s_ssid_length),
        .s_ssid_byte      (s_ssid_byte),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_frame_byte     (m_frame_byte),
        .m_frame_last     (m_frame_last),
        .m_frame_count    (m_frame_count)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    function automatic void add_byte(ref beacon_word_t q [$], input logic [7:0] b,
                                     input logic is_last);
        q.push_back(beacon_word_t'{b, is_last, frames_done});
    endfunction

    // Rates element, channel element, and the count moves on before the last byte.
    function automatic void close_frame(ref beacon_word_t q [$]);
        int i;
        for (i = 0; i < 10; i++) add_byte(q, RATES[i], 1'b0);
        add_byte(q, 8'h03, 1'b0);
        add_byte(q, 8'h01, 1'b0);
        frames_done = frames_done + 32'd1;
        add_byte(q, bcn_chan, 1'b1);
        frame_open = 1'b0;
        ssid_left  = '0;
    endfunction

    function automatic void predict_beacon(input logic req, input logic [47:0] mac,
                                           input logic [7:0] chan, input logic [5:0] len,
                                           input logic [7:0] ssid,
                                           ref beacon_word_t q [$]);
        logic [5:0] n;
        int i, j;
        if (req == REQ_START) begin
            n = (len > 6'(MAX_SSID)) ? 6'(MAX_SSID) : len;
            bcn_addr     = mac;
            bcn_addr[40] = 1'b0;
            bcn_addr[41] = 1'b1;
            bcn_chan     = chan;
            ssid_left    = n;
            frame_open   = 1'b1;
            add_byte(q, 8'h80, 1'b0);
            for (i = 0; i < 3; i++) add_byte(q, 8'h00, 1'b0);
            for (i = 0; i < 6; i++) add_byte(q, 8'hff, 1'b0);
            for (j = 0; j < 2; j++)
                for (i = 0; i < 6; i++) add_byte(q, bcn_addr[47 - 8 * i -: 8], 1'b0);
            for (i = 0; i < 15; i++) add_byte(q, HDR_TAIL[i], 1'b0);
            add_byte(q, {2'b00, n}, 1'b0);
            if (n == 0) close_frame(q);
        end else if (frame_open && ssid_left != 0) begin
            add_byte(q, ssid, 1'b0);
            ssid_left = ssid_left - 6'd1;
            if (ssid_left == 0) close_frame(q);
        end
    endfunction

    function automatic void check_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
        if (got !== want) begin
            mismatches++;
            $display("%0t: %s expected %0h, got %0h", $time, name, want, got);
        end
    endfunction

    // Inputs are sampled before this edge's updates land, so word acceptance
    // is seen first and a same-edge result can never overtake its prediction.
    always @(posedge aclk) begin : scoreboard
        beacon_word_t want;
        logic moved;
        moved = 1'b0;
        if (s_valid && s_ready) begin
            moved = 1'b1;
            if (row_check == CHECK_PREDICTED) begin
                predict_beacon(s_req_type, s_source_mac, s_channel_number, s_ssid_length,
                               s_ssid_byte, expected_bytes);
            end else begin
                discarded.delete();
                predict_beacon(s_req_type, s_source_mac, s_channel_number, s_ssid_length,
                               s_ssid_byte, discarded);
                if (row_check == CHECK_ONE_WORD)
                    expected_bytes.push_back(beacon_word_t'{row_byte, 1'b0, row_cnt});
            end
        end
        if (m_valid && m_ready) begin
            moved = 1'b1;
            if (expected_bytes.size() == 0) begin
                check_field("unexpected frame_byte", 32'hxxxxxxxx, {24'd0, m_frame_byte});
            end else begin
                want = expected_bytes.pop_front();
                check_field("frame_byte", {24'd0, want.octet}, {24'd0, m_frame_byte});
                check_field("frame_last", {31'd0, want.is_last}, {31'd0, m_frame_last});
                check_field("frame_count", want.frame_cnt, m_frame_count);
            end
        end
        stalled_cycles = moved ? 0 : stalled_cycles + 1;
        if (stalled_cycles >= WATCHDOG_LIMIT) begin
            $display("beacon_frame_serializer verification failed");
            $finish;
        end
    end

    initial begin : receiver
        forever begin
            @(posedge aclk);
            if (hold_off_req) begin
                hold_off_req = 1'b0;
                m_ready <= 1'b0;
                repeat (HOLD_OFF) @(posedge aclk);
            end else begin
                m_ready <= ($urandom_range(99) < rx_idle_pct) ? 1'b0 : 1'b1;
            end
        end
    end

    // Called at a clock edge; returns at the edge that accepts the word.
    task automatic offer_word(input stim_row_t w);
        while ($urandom_range(99) < tx_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid          <= 1'b1;
        s_req_type       <= w.req;
        s_source_mac     <= w.mac;
        s_channel_number <= w.chan;
        s_ssid_length    <= w.len;
        s_ssid_byte      <= w.ssid;
        row_check        <= w.check;
        row_byte         <= w.t_byte;
        row_cnt          <= w.t_cnt;
        do @(posedge aclk); while (!s_ready);
    endtask

    task automatic drain_frames();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (expected_bytes.size() != 0) @(posedge aclk);
    endtask

    // Unused fields carry noise so that every input bit toggles.
    function automatic stim_row_t random_row(input logic req);
        stim_row_t w;
        w.req    = req;
        w.mac    = {16'($urandom), 32'($urandom)};
        w.chan   = 8'($urandom);
        w.len    = 6'($urandom);
        w.ssid   = 8'($urandom);
        w.check  = CHECK_PREDICTED;
        w.t_byte = '0;
        w.t_cnt  = '0;
        return w;
    endfunction

    task automatic send_random_frame();
        stim_row_t w;
        int roll, n, cut, k;
        w    = random_row(REQ_START);
        roll = $urandom_range(99);
        if (roll < 10)
            w.len = 6'd0;
        else if (roll < 70)
            w.len = 6'($urandom_range(1, 6));
        else if (roll < 85)
            w.len = 6'($urandom_range(7, 31));
        else if (roll < 92)
            w.len = 6'(MAX_SSID);
        else
            w.len = 6'($urandom_range(MAX_SSID + 1, 63));
        offer_word(w);
        fed_words++;
        n   = (w.len > MAX_SSID) ? MAX_SSID : w.len;
        cut = n;
        // Now and then the frame is cut short by the next start word.
        if (n > 1 && $urandom_range(99) < 8) cut = $urandom_range(1, n - 1);
        for (k = 0; k < cut; k++) begin
            offer_word(random_row(REQ_SSID));
            fed_words++;
        end
        if (cut == n && $urandom_range(99) < 15)
            repeat ($urandom_range(1, 3)) offer_word(random_row(REQ_SSID));
    endtask

    initial begin : stimulus
        int row, pass;
        repeat (2) @(posedge aclk);
        aresetn     <= 1'b1;
        tx_idle_pct = 20;
        rx_idle_pct = 82;
        for (row = 0; row < DIRECTED_ROWS; row++) offer_word(directed_rows[row]);
        drain_frames();
        for (pass = 0; pass < 3; pass++) begin
            unique case (pass)
                0: begin
                    tx_idle_pct = 20;
                    rx_idle_pct = 82;
                    hold_off_req = 1'b1;
                end
                1: begin
                    tx_idle_pct = 82;
                    rx_idle_pct = 20;
                end
                default: begin
                    tx_idle_pct = 0;
                    rx_idle_pct = 0;
                end
            endcase
            while (fed_words < (pass + 1) * WORDS_PER_PASS) send_random_frame();
            drain_frames();
        end
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (mismatches == 0 && expected_bytes.size() == 0)
            $display("beacon_frame_serializer verification clean");
        else
            $display("beacon_frame_serializer verification failed");
        $finish;
    end

endmodule

FILE: files.f
hdl/bfs_pkg.sv
hdl/bfs_out_queue.sv
hdl/bfs_frame_ctrl.sv
hdl/beacon_frame_serializer.sv
tb/sv/beacon_frame_serializer_test.sv
